>>> hdl/npc_pkg.sv
package npc_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] query_red;
        logic [7:0] query_green;
        logic [7:0] query_blue;
        logic [7:0] query_index;
    } query_beat_t;

    typedef struct packed {
        logic [7:0]  match_index;
        logic [7:0]  match_red;
        logic [7:0]  match_green;
        logic [7:0]  match_blue;
        logic [17:0] match_distance;
    } result_beat_t;

    localparam logic FUNC_NEAREST = 1'b0;
    localparam logic FUNC_LOOKUP  = 1'b1;

    localparam int PALETTE_DEPTH = 256;

    typedef logic [23:0] palette_t [PALETTE_DEPTH];

    localparam logic [23:0] SYS_COLOURS [16] = '{
        24'h000000, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
        24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
    };

    localparam logic [7:0] CUBE_LEVELS [6] = '{
        8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
    };

    // Entries are packed as {red, green, blue}.
    function automatic palette_t build_palette();
        palette_t   p;
        int         k;
        logic [7:0] v;
        for (int i = 0; i < 16; i++)
        begin
            p[i] = SYS_COLOURS[i];
        end
        k = 16;
        for (int r = 0; r < 6; r++)
        begin
            for (int g = 0; g < 6; g++)
            begin
                for (int b = 0; b < 6; b++)
                begin
                    p[k] = {CUBE_LEVELS[r], CUBE_LEVELS[g], CUBE_LEVELS[b]};
                    k = k + 1;
                end
            end
        end
        for (int i = 0; i < 24; i++)
        begin
            v = 8'(8 + 10 * i);
            p[232 + i] = {v, v, v};
        end
        return p;
    endfunction

    localparam palette_t PALETTE = build_palette();

endpackage

>>> hdl/nearest_palette_colour.sv
// Channel   Direction  Handshake                    Payload
// query     in         query_valid / query_ready    query_beat_t (mode, color, index)
// result    out        result_valid / result_ready  result_beat_t (index, color, distance)
//
// In nearest-color mode the palette ROM delivers one entry per cycle and the
// search walks every entry in order.
// Lookup mode does one ROM read plus the result hand-off.
// A new query beat is taken once the previous result has moved into the output
// register, even if that result has not yet been taken downstream.
// A stalled result only holds the block in its final state; reset empties the
// output register and returns the sequencer to idle.
module nearest_palette_colour
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         query_valid,
    output logic         query_ready,
    input  query_beat_t  query,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LOOK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Index of the last palette entry that takes part in the search.
    localparam logic [7:0] LAST_INDEX = 8'(PALETTE_ENTRIES - 1);
    localparam logic [8:0] ENTRY_COUNT = 9'(PALETTE_ENTRIES);

    // Control registers.
    logic [1:0] state_reg, state_next;
    logic       issue_on_reg, issue_on_next;
    logic [7:0] scan_addr_reg, scan_addr_next;
    logic       v1_reg, v1_next;
    logic       v1_last_reg, v1_last_next;
    logic       v2_reg, v2_next;
    logic       v2_last_reg, v2_last_next;
    logic       first_reg, first_next;
    logic       out_valid_reg, out_valid_next;

    // Payload registers.
    logic [7:0]   v1_idx_reg, v1_idx_next;
    logic [7:0]   v2_idx_reg, v2_idx_next;
    logic [23:0]  v2_rgb_reg, v2_rgb_next;
    logic [15:0]  sq_r_reg, sq_r_next;
    logic [15:0]  sq_g_reg, sq_g_next;
    logic [15:0]  sq_b_reg, sq_b_next;
    logic [7:0]   qry_r_reg, qry_r_next;
    logic [7:0]   qry_g_reg, qry_g_next;
    logic [7:0]   qry_b_reg, qry_b_next;
    logic         in_range_reg, in_range_next;
    logic [7:0]   best_idx_reg, best_idx_next;
    logic [23:0]  best_rgb_reg, best_rgb_next;
    logic [17:0]  best_dist_reg, best_dist_next;
    result_beat_t out_beat_reg, out_beat_next;

    // Palette ROM with a registered read port.
    logic [7:0]  rd_addr;
    logic [23:0] rom_q_reg;

    logic        accept;
    logic        out_load;
    logic [7:0]  diff_r, diff_g, diff_b;
    logic [17:0] dist_sum;

    assign query_ready  = (state_reg == ST_IDLE);
    assign accept       = query_valid && query_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_beat_reg;

    // In idle the read address comes straight from the incoming beat so the
    // first entry (or the looked-up entry) is fetched on the accepting edge.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = (query.func == FUNC_LOOKUP) ? query.query_index : 8'd0;
        end
        else
        begin
            rd_addr = scan_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= PALETTE[rd_addr];
    end

    // Stage one: per-channel absolute differences against the fetched entry.
    assign diff_r = (rom_q_reg[23:16] > qry_r_reg) ? (rom_q_reg[23:16] - qry_r_reg)
                                                   : (qry_r_reg - rom_q_reg[23:16]);
    assign diff_g = (rom_q_reg[15:8] > qry_g_reg) ? (rom_q_reg[15:8] - qry_g_reg)
                                                  : (qry_g_reg - rom_q_reg[15:8]);
    assign diff_b = (rom_q_reg[7:0] > qry_b_reg) ? (rom_q_reg[7:0] - qry_b_reg)
                                                 : (qry_b_reg - rom_q_reg[7:0]);

    // Stage two: the squared distance that is compared against the best so far.
    assign dist_sum = {2'b00, sq_r_reg} + {2'b00, sq_g_reg} + {2'b00, sq_b_reg};

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next     = state_reg;
        issue_on_next  = issue_on_reg;
        scan_addr_next = scan_addr_reg;
        v1_next        = 1'b0;
        v1_last_next   = 1'b0;
        v1_idx_next    = v1_idx_reg;
        first_next     = first_reg;
        qry_r_next     = qry_r_reg;
        qry_g_next     = qry_g_reg;
        qry_b_next     = qry_b_reg;
        in_range_next  = in_range_reg;
        best_idx_next  = best_idx_reg;
        best_rgb_next  = best_rgb_reg;
        best_dist_next = best_dist_reg;
        out_beat_next  = out_beat_reg;
        out_valid_next = out_valid_reg && !result_ready;

        // Stage one registers follow the ROM output every cycle.
        v2_next      = v1_reg;
        v2_last_next = v1_last_reg;
        v2_idx_next  = v1_idx_reg;
        v2_rgb_next  = rom_q_reg;
        sq_r_next    = {8'd0, diff_r} * {8'd0, diff_r};
        sq_g_next    = {8'd0, diff_g} * {8'd0, diff_g};
        sq_b_next    = {8'd0, diff_b} * {8'd0, diff_b};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    qry_r_next    = query.query_red;
                    qry_g_next    = query.query_green;
                    qry_b_next    = query.query_blue;
                    best_idx_next = query.query_index;
                    in_range_next = ({1'b0, query.query_index} < ENTRY_COUNT);
                    if (query.func == FUNC_LOOKUP)
                    begin
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        // Entry zero is read on this edge; the rest follow.
                        state_next     = ST_SCAN;
                        issue_on_next  = 1'b1;
                        scan_addr_next = 8'd1;
                        v1_next        = 1'b1;
                        v1_idx_next    = 8'd0;
                        v1_last_next   = (LAST_INDEX == 8'd0);
                        first_next     = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_on_reg)
                begin
                    v1_next        = 1'b1;
                    v1_idx_next    = scan_addr_reg;
                    v1_last_next   = (scan_addr_reg == LAST_INDEX);
                    scan_addr_next = scan_addr_reg + 8'd1;
                    if (scan_addr_reg == LAST_INDEX)
                    begin
                        issue_on_next = 1'b0;
                    end
                end
                if (v2_reg)
                begin
                    // Strictly smaller wins, so ties keep the lowest index.
                    first_next = 1'b0;
                    if (first_reg || (dist_sum < best_dist_reg))
                    begin
                        best_dist_next = dist_sum;
                        best_idx_next  = v2_idx_reg;
                        best_rgb_next  = v2_rgb_reg;
                    end
                    if (v2_last_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOOK:
            begin
                // Indexes past the active palette read back as black.
                best_rgb_next  = in_range_reg ? rom_q_reg : 24'd0;
                best_dist_next = 18'd0;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next               = 1'b1;
            out_beat_next.match_index    = best_idx_reg;
            out_beat_next.match_red      = best_rgb_reg[23:16];
            out_beat_next.match_green    = best_rgb_reg[15:8];
            out_beat_next.match_blue     = best_rgb_reg[7:0];
            out_beat_next.match_distance = best_dist_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_on_reg  <= 1'b0;
            scan_addr_reg <= 8'd0;
            v1_reg        <= 1'b0;
            v1_last_reg   <= 1'b0;
            v2_reg        <= 1'b0;
            v2_last_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_on_reg  <= issue_on_next;
            scan_addr_reg <= scan_addr_next;
            v1_reg        <= v1_next;
            v1_last_reg   <= v1_last_next;
            v2_reg        <= v2_next;
            v2_last_reg   <= v2_last_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_idx_reg    <= v1_idx_next;
        v2_idx_reg    <= v2_idx_next;
        v2_rgb_reg    <= v2_rgb_next;
        sq_r_reg      <= sq_r_next;
        sq_g_reg      <= sq_g_next;
        sq_b_reg      <= sq_b_next;
        qry_r_reg     <= qry_r_next;
        qry_g_reg     <= qry_g_next;
        qry_b_reg     <= qry_b_next;
        in_range_reg  <= in_range_next;
        best_idx_reg  <= best_idx_next;
        best_rgb_reg  <= best_rgb_next;
        best_dist_reg <= best_dist_next;
        out_beat_reg  <= out_beat_next;
    end

`ifndef ASSERT_OFF
    // A new result only ever comes from the final state of the sequencer.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result became valid outside the final state");

    // The compare pipeline only carries entries while a search runs.
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg) |-> (state_reg == ST_SCAN))
        else $error("search pipeline active outside a search");

    // The search finishes only after every entry has been issued.
    a_done_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !issue_on_reg)
        else $error("search finished with entries still to read");

    // The best distance never grows once the first entry has been compared.
    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && !first_reg && $past(state_reg == ST_SCAN)
            && $past(!first_reg))
        |-> (best_dist_reg <= $past(best_dist_reg)))
        else $error("best distance increased during a search");
`endif

endmodule
